/* rtl/pipd_pkg.sv */
// ----------------------------------------------------------------------------
// pipd_pkg
// Shared widths, register indexes, tracker codes and the gap-to-step table of
// the peak interval phase decoder.
// ----------------------------------------------------------------------------
package pipd_pkg;

    // Converter sample width
    localparam int SAMPLE_BITS = 12;

    // Configuration registers
    localparam int THRESH_BITS    = 12;
    localparam int LIMIT_BITS     = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_LIMIT   = 1'b1;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2000;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 7'd60;

    // Width used for the peak compare
    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    // Output field widths
    localparam int SYM_BITS   = 3;
    localparam int INDEX_BITS = 8;
    localparam int GAP_BITS   = 8;

    // Symbol codes
    localparam logic [SYM_BITS-1:0] PHASE_INVALID = 3'd4;

    // Sync tracker states
    localparam logic [1:0] ST_IDLE0 = 2'd0;
    localparam logic [1:0] ST_IDLE1 = 2'd1;
    localparam logic [1:0] ST_TYPE  = 2'd2;
    localparam logic [1:0] ST_SYNC  = 2'd3;

    // Frame position after a sync
    localparam logic [INDEX_BITS-1:0] SYNC_POSITION = 8'd4;

    // Phase step: bit 2 flags a gap outside every valid window
    typedef logic [2:0] t_step;
    localparam t_step STEP_ZERO    = 3'b000;
    localparam t_step STEP_ONE     = 3'b001;
    localparam t_step STEP_TWO     = 3'b010;
    localparam t_step STEP_THREE   = 3'b011;
    localparam t_step STEP_INVALID = 3'b100;

    // Gap in samples to phase step
    function automatic t_step gap_step(input logic [GAP_BITS-1:0] gap);
        t_step step;
        if ((gap >= 8'd7 && gap <= 8'd12) || (gap >= 8'd39 && gap <= 8'd41))
            step = STEP_ONE;
        else if ((gap >= 8'd15 && gap <= 8'd20) || (gap >= 8'd47 && gap <= 8'd49))
            step = STEP_TWO;
        else if ((gap >= 8'd23 && gap <= 8'd28) || (gap >= 8'd55 && gap <= 8'd57))
            step = STEP_THREE;
        else if (gap >= 8'd31 && gap <= 8'd33)
            step = STEP_ZERO;
        else
            step = STEP_INVALID;
        return step;
    endfunction

endpackage

/* rtl/peak_interval_phase_decoder_top.sv */
// ----------------------------------------------------------------------------
// peak_interval_phase_decoder_top
// Decodes phase symbols from the spacing of peaks in a converter sample stream.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle when the output side keeps up; a
// symbol is registered in the result register from the sample held in the
// input register. The per-sample work - threshold compare, gap
// counter, gap window table, phase add and sync tracker update - is one pass
// of logic between those two registers, so the sustained rate is one sample
// per cycle. Samples that cause no symbol produce no output request. Write
// the configuration registers only while no sample is in flight.
module peak_interval_phase_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pipd_pkg::SAMPLE_BITS-1:0]    i_sample,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pipd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pipd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // symbol output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pipd_pkg::SYM_BITS-1:0]       o_symbol,
    output logic [pipd_pkg::INDEX_BITS-1:0]     o_symbol_index,
    output logic [1:0]                          o_frame_state,
    output logic                                o_sync_found,
    output logic                                o_timed_out
);
    import pipd_pkg::*;

    // Configuration
    logic [THRESH_BITS-1:0] r_threshold;
    logic [LIMIT_BITS-1:0]  r_limit;

    // Input register
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;

    // Decoder state
    logic                   r_started;
    logic                   r_odd;
    logic                   r_have_ref;
    logic [LIMIT_BITS-1:0]  r_gap_count;
    logic [SYM_BITS-1:0]    r_phase;
    logic [1:0]             r_sync_state;
    logic [INDEX_BITS-1:0]  r_position;

    // Result register
    logic                   r_out_valid;
    logic [SYM_BITS-1:0]    r_symbol;
    logic [INDEX_BITS-1:0]  r_symbol_index;
    logic [1:0]             r_frame_state;
    logic                   r_sync_found;
    logic                   r_timed_out;

    // Next values
    logic                   n_have_ref;
    logic [LIMIT_BITS-1:0]  n_gap_count;
    logic [SYM_BITS-1:0]    n_phase;
    logic [1:0]             n_sync_state;
    logic [INDEX_BITS-1:0]  n_position;
    logic                   n_emit;
    logic                   n_found;

    // Datapath terms
    logic                   fire;
    logic                   accept;
    logic                   examine;
    logic                   is_peak;
    logic                   timeout;
    logic [LIMIT_BITS:0]    count_inc;
    logic [GAP_BITS-1:0]    gap;
    t_step                  step;
    t_step                  step_used;

    // Handshakes
    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Peak detection and gap measurement
    assign examine   = r_started && !r_odd;
    assign is_peak   = CMP_BITS'(r_in_sample) > CMP_BITS'(r_threshold);
    assign count_inc = {1'b0, r_gap_count} + (LIMIT_BITS+1)'(1);
    assign timeout   = count_inc >= {1'b0, r_limit};
    assign gap       = GAP_BITS'({count_inc, 1'b0});
    assign step      = gap_step(gap);
    assign step_used = is_peak ? step : STEP_ONE;

    // Symbol, phase and sync tracker
    always_comb begin
        n_have_ref   = r_have_ref;
        n_gap_count  = r_gap_count;
        n_phase      = r_phase;
        n_sync_state = r_sync_state;
        n_position   = r_position;
        n_emit       = 1'b0;
        n_found      = 1'b0;
        if (examine) begin
            if (!r_have_ref) begin
                if (is_peak) begin
                    n_have_ref  = 1'b1;
                    n_gap_count = '0;
                end
            end else if (is_peak || timeout) begin
                n_emit      = 1'b1;
                n_gap_count = '0;
            end else begin
                n_gap_count = count_inc[LIMIT_BITS-1:0];
            end
        end
        if (n_emit) begin
            // invalid phase is sticky
            if (r_phase[2] || step_used[2])
                n_phase = PHASE_INVALID;
            else
                n_phase = {1'b0, r_phase[1:0] + step_used[1:0]};
            case (r_sync_state)
                ST_IDLE0: begin
                    if (n_phase == 3'd0) n_sync_state = ST_IDLE1;
                end
                ST_IDLE1: begin
                    if (n_phase == 3'd2)      n_sync_state = ST_TYPE;
                    else if (n_phase == 3'd3) n_sync_state = ST_IDLE0;
                end
                ST_TYPE: begin
                    n_sync_state = (n_phase == 3'd0) ? ST_SYNC : ST_IDLE0;
                end
                ST_SYNC: begin
                    if (n_phase == 3'd2) n_found = 1'b1;
                    else                 n_sync_state = ST_IDLE0;
                end
                default: begin
                    n_sync_state = ST_IDLE0;
                end
            endcase
            n_position = n_found ? SYNC_POSITION : r_position + INDEX_BITS'(1);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_limit     <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PEAK_THRESHOLD: r_threshold <= i_cfg_data[THRESH_BITS-1:0];
                CFG_SEARCH_LIMIT:   r_limit     <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_sample;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_odd        <= 1'b0;
            r_have_ref   <= 1'b0;
            r_gap_count  <= '0;
            r_phase      <= '0;
            r_sync_state <= ST_IDLE0;
            r_position   <= '0;
        end else if (fire) begin
            r_started    <= 1'b1;
            r_odd        <= r_started ? !r_odd : 1'b1;
            r_have_ref   <= n_have_ref;
            r_gap_count  <= n_gap_count;
            r_phase      <= n_phase;
            r_sync_state <= n_sync_state;
            r_position   <= n_position;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= fire && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_emit) begin
            r_symbol       <= n_phase;
            r_symbol_index <= r_position;
            r_frame_state  <= n_sync_state;
            r_sync_found   <= n_found;
            r_timed_out    <= !is_peak;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_symbol;
    assign o_symbol_index = r_symbol_index;
    assign o_frame_state  = r_frame_state;
    assign o_sync_found   = r_sync_found;
    assign o_timed_out    = r_timed_out;

endmodule

/* rtl/pipd_checker.sv */
// ----------------------------------------------------------------------------
// pipd_props
// Port-level checks on the peak interval phase decoder, bound to its top.
// ----------------------------------------------------------------------------
module pipd_props (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [pipd_pkg::SYM_BITS-1:0]   o_symbol,
    input logic [pipd_pkg::INDEX_BITS-1:0] o_symbol_index,
    input logic [1:0]                      o_frame_state,
    input logic                            o_sync_found,
    input logic                            o_timed_out
);
    import pipd_pkg::*;

    // No symbol request right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("symbol request right after reset");

    // A stalled symbol request holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_symbol)
            && $stable(o_symbol_index) && $stable(o_frame_state)
            && $stable(o_sync_found) && $stable(o_timed_out))
        else $error("stalled symbol request changed");

    // Symbols stay in range
    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_symbol <= PHASE_INVALID)
        else $error("symbol out of range");

    // A sync completes only on symbol 2 while in sync
    a_sync_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sync_found |-> o_frame_state == ST_SYNC && o_symbol == 3'd2)
        else $error("sync flagged on wrong symbol or state");

    // Sync is entered on 0 after type, kept on 2
    a_sync_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_state == ST_SYNC |-> o_symbol == 3'd0 || o_symbol == 3'd2)
        else $error("sync state on unexpected symbol");

endmodule

bind peak_interval_phase_decoder_top pipd_props u_pipd_props (.*);
